FILE: hdl/pkca_pkg.sv
// Shared types, codes and defaults for the per-key connection admission core.
// No dependencies; imported by every module under hdl/.
package pkca_pkg;

    localparam int KEY_COUNT_DEFAULT         = 64;
    localparam int KEY_COUNT_WIDTH_DEFAULT   = 12;
    localparam int TOTAL_COUNT_WIDTH_DEFAULT = 16;

    localparam logic [15:0] TOTAL_LIMIT_RESET   = 16'd1000;
    localparam logic [11:0] PER_KEY_LIMIT_RESET = 12'd100;

    // word select (paddr[2]) of the configuration registers
    localparam logic REG_TOTAL_LIMIT   = 1'b0;
    localparam logic REG_PER_KEY_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        OP_TRY    = 2'd0,
        OP_FINISH = 2'd1,
        OP_ADD    = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_SAT   = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } back_state_t;

    // classified command as it sits in the queue
    typedef struct packed {
        op_t         op;
        logic [5:0]  key;
        logic        in_range;
        logic        pre_ok;      // client under limit and not throttled
        logic [15:0] queued;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [15:0] total_limit;
        logic [11:0] per_key_limit;
    } cfg_t;

endpackage

FILE: hdl/pkca_front.sv
// Front end: command acceptance and classification into a queue item.
// Depends on pkca_pkg.
module pkca_front
    import pkca_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEFAULT
)
(
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [5:0]  key_index,
    input  logic [15:0] queued_requests,
    input  logic [15:0] client_connections,
    input  logic [15:0] client_limit,
    input  logic        throttle_denied,
    input  logic        clearing,
    input  q_status_t   q_status,
    output logic        push,
    output item_t       item
);

    assign busy = clearing || q_status.full;
    assign push = start && !busy;

    always_comb
    begin
        item.op       = op_t'(opcode);
        item.key      = key_index;
        item.in_range = (32'(key_index) < 32'(KEY_COUNT));
        item.pre_ok   = (client_connections < client_limit) && !throttle_denied;
        item.queued   = queued_requests;
    end

endmodule

FILE: hdl/pkca_queue.sv
// Two-entry queue between front and back ends.
// Depends on pkca_pkg (item_t, q_status_t).
module pkca_queue
    import pkca_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  item_t     din,
    input  logic      pop,
    output item_t     dout,
    output q_status_t status
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign dout         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: hdl/pkca_back.sv
// Back end: per-key counter memory, global totals, read-modify-write sequencer.
// Depends on pkca_pkg.
module pkca_back
    import pkca_pkg::*;
#(
    parameter int KEY_COUNT         = KEY_COUNT_DEFAULT,
    parameter int KEY_COUNT_WIDTH   = KEY_COUNT_WIDTH_DEFAULT,
    parameter int TOTAL_COUNT_WIDTH = TOTAL_COUNT_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  q_status_t   q_status,
    input  item_t       q_item,
    output logic        pop,
    output logic        clearing,
    output logic        done,
    output logic        granted,
    output logic [11:0] key_open_count,
    output logic [11:0] key_pending_count,
    output logic [15:0] all_open_count,
    output logic [15:0] all_pending_count,
    output logic [1:0]  error_code
);

    localparam int KW   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KCW  = KEY_COUNT_WIDTH;
    localparam int TCW  = TOTAL_COUNT_WIDTH;
    localparam int RW   = 2 * KCW;
    localparam int PKW  = (KCW + 1 > 12) ? KCW + 1 : 12;
    localparam int TSW  = (TCW + 1 > 16) ? TCW + 1 : 16;
    localparam int QW   = (KCW > 16) ? KCW : 16;
    localparam logic [KCW-1:0] KEY_MAX   = {KCW{1'b1}};
    localparam logic [TCW-1:0] TOTAL_MAX = {TCW{1'b1}};
    localparam logic [KW-1:0]  LAST_KEY  = KW'(KEY_COUNT - 1);

    // row layout: {open, pending}
    logic [RW-1:0]  mem [KEY_COUNT];
    logic [RW-1:0]  rd_data_reg;
    logic           rd_en;
    logic [KW-1:0]  rd_addr;
    logic           mem_we;
    logic [KW-1:0]  mem_waddr;
    logic [RW-1:0]  mem_wdata;

    back_state_t    state_reg;
    back_state_t    state_next;
    logic [KW-1:0]  clr_idx_reg;
    logic [KW-1:0]  clr_idx_next;
    item_t          item_reg;
    item_t          item_next;
    logic [TCW-1:0] open_total_reg;
    logic [TCW-1:0] open_total_next;
    logic [TCW-1:0] pending_total_reg;
    logic [TCW-1:0] pending_total_next;

    logic           done_reg;
    logic           done_next;
    logic           granted_reg;
    logic           granted_next;
    logic [11:0]    kopen_reg;
    logic [11:0]    kopen_next;
    logic [11:0]    kpend_reg;
    logic [11:0]    kpend_next;
    err_t           err_reg;
    err_t           err_next;

    assign clearing          = (state_reg == ST_CLEAR);
    assign done              = done_reg;
    assign granted           = granted_reg;
    assign key_open_count    = kopen_reg;
    assign key_pending_count = kpend_reg;
    assign all_open_count    = 16'(open_total_reg);
    assign all_pending_count = 16'(pending_total_reg);
    assign error_code        = err_reg;

    always_comb
    begin
        logic [KCW-1:0] po;
        logic [KCW-1:0] pp;
        logic [KCW-1:0] po_n;
        logic [KCW-1:0] pp_n;
        logic [TCW-1:0] ot_n;
        logic [TCW-1:0] pt_n;
        logic [KCW:0]   ksum;
        logic [TCW:0]   tsum;
        logic           ok;
        err_t           err;

        po   = rd_data_reg[RW-1:KCW];
        pp   = rd_data_reg[KCW-1:0];
        po_n = po;
        pp_n = pp;
        ot_n = open_total_reg;
        pt_n = pending_total_reg;
        ksum = {1'b0, po} + {1'b0, pp};
        tsum = {1'b0, open_total_reg} + {1'b0, pending_total_reg};
        ok   = 1'b0;
        err  = ERR_NONE;

        state_next         = state_reg;
        clr_idx_next       = clr_idx_reg;
        item_next          = item_reg;
        open_total_next    = open_total_reg;
        pending_total_next = pending_total_reg;
        pop                = 1'b0;
        rd_en              = 1'b0;
        rd_addr            = KW'(q_item.key);
        mem_we             = 1'b0;
        mem_waddr          = KW'(item_reg.key);
        mem_wdata          = {po_n, pp_n};
        done_next          = 1'b0;
        granted_next       = granted_reg;
        kopen_next         = kopen_reg;
        kpend_next         = kpend_reg;
        err_next           = err_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + KW'(1);
                if (clr_idx_reg == LAST_KEY)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    rd_en      = 1'b1;
                    item_next  = q_item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (item_reg.op)
                    OP_TRY:
                    begin
                        ok = item_reg.pre_ok
                             && (TSW'(tsum) < TSW'(cfg.total_limit))
                             && (PKW'(ksum) < PKW'(cfg.per_key_limit))
                             && (QW'(pp) < QW'(item_reg.queued));
                        if (ok)
                        begin
                            if (pp == KEY_MAX) err = ERR_SAT;
                            else               pp_n = pp + KCW'(1);
                            if (pending_total_reg == TOTAL_MAX) err = ERR_SAT;
                            else pt_n = pending_total_reg + TCW'(1);
                        end
                    end
                    OP_FINISH:
                    begin
                        if (pp == '0) err = ERR_UNDER;
                        else          pp_n = pp - KCW'(1);
                        if (pending_total_reg == '0) err = ERR_UNDER;
                        else pt_n = pending_total_reg - TCW'(1);
                    end
                    OP_ADD:
                    begin
                        if (po == KEY_MAX) err = ERR_SAT;
                        else               po_n = po + KCW'(1);
                        if (open_total_reg == TOTAL_MAX) err = ERR_SAT;
                        else ot_n = open_total_reg + TCW'(1);
                    end
                    default:
                    begin
                        if (po == '0) err = ERR_UNDER;
                        else          po_n = po - KCW'(1);
                        if (open_total_reg == '0) err = ERR_UNDER;
                        else ot_n = open_total_reg - TCW'(1);
                    end
                endcase

                mem_wdata = {po_n, pp_n};
                done_next = 1'b1;
                if (item_reg.in_range)
                begin
                    mem_we             = 1'b1;
                    open_total_next    = ot_n;
                    pending_total_next = pt_n;
                    granted_next       = ok;
                    kopen_next         = 12'(po_n);
                    kpend_next         = 12'(pp_n);
                    err_next           = err;
                end
                else
                begin
                    granted_next = 1'b0;
                    kopen_next   = '0;
                    kpend_next   = '0;
                    err_next     = ERR_NONE;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_idx_reg       <= '0;
            open_total_reg    <= '0;
            pending_total_reg <= '0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_idx_reg       <= clr_idx_next;
            open_total_reg    <= open_total_next;
            pending_total_reg <= pending_total_next;
            done_reg          <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        granted_reg <= granted_next;
        kopen_reg   <= kopen_next;
        kpend_reg   <= kpend_next;
        err_reg     <= err_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/per_key_connection_admission_core.sv
// Top level of the per-key connection admission core: APB registers and wiring.
// Depends on pkca_pkg, pkca_front, pkca_queue, pkca_back.
//
// Usage:
//   Command channel: drive opcode, key_index and the try fields, raise start;
//   the command transfers at a clock edge with start high and busy low.
//   Result channel: done pulses for one cycle with granted, the key's open and
//   pending counts, the global totals and error_code. The receiver cannot
//   stall, so every result must be taken in the cycle it is shown.
//   The back end takes one command at a time, set by the read-modify-write
//   of the per-key counter memory (registered read, then update/write).
//   A two-entry queue lets the front end take commands while the back end
//   works; busy rises when that queue is full and during the clearing pass.
//   Reset: totals clear at once, then a clearing pass writes zero into every
//   key row, one per cycle; busy is high during the pass.
//   Configuration: APB, total_limit at 0x0 and per_key_limit at 0x4 (decoded
//   by paddr[2]); write only while no command is in flight.
module per_key_connection_admission_core
    import pkca_pkg::*;
#(
    parameter int KEY_COUNT         = KEY_COUNT_DEFAULT,
    parameter int KEY_COUNT_WIDTH   = KEY_COUNT_WIDTH_DEFAULT,
    parameter int TOTAL_COUNT_WIDTH = TOTAL_COUNT_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [5:0]  key_index,
    input  logic [15:0] queued_requests,
    input  logic [15:0] client_connections,
    input  logic [15:0] client_limit,
    input  logic        throttle_denied,
    // result channel
    output logic        done,
    output logic        granted,
    output logic [11:0] key_open_count,
    output logic [11:0] key_pending_count,
    output logic [15:0] all_open_count,
    output logic [15:0] all_pending_count,
    output logic [1:0]  error_code
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      cfg_wr;
    logic      clearing;
    logic      push;
    logic      pop;
    item_t     front_item;
    item_t     q_item;
    q_status_t q_status;

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_TOTAL_LIMIT:   cfg_next.total_limit   = pwdata[15:0];
                REG_PER_KEY_LIMIT: cfg_next.per_key_limit = pwdata[11:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TOTAL_LIMIT:   prdata = {16'd0, cfg_reg.total_limit};
            REG_PER_KEY_LIMIT: prdata = {20'd0, cfg_reg.per_key_limit};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_limit   <= TOTAL_LIMIT_RESET;
            cfg_reg.per_key_limit <= PER_KEY_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- front end: accept and classify ----------------
    pkca_front #(
        .KEY_COUNT (KEY_COUNT)
    ) u_front (
        .start              (start),
        .busy               (busy),
        .opcode             (opcode),
        .key_index          (key_index),
        .queued_requests    (queued_requests),
        .client_connections (client_connections),
        .client_limit       (client_limit),
        .throttle_denied    (throttle_denied),
        .clearing           (clearing),
        .q_status           (q_status),
        .push               (push),
        .item               (front_item)
    );

    // ---------------- command queue ----------------
    pkca_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (front_item),
        .pop    (pop),
        .dout   (q_item),
        .status (q_status)
    );

    // ---------------- back end: counter update ----------------
    pkca_back #(
        .KEY_COUNT         (KEY_COUNT),
        .KEY_COUNT_WIDTH   (KEY_COUNT_WIDTH),
        .TOTAL_COUNT_WIDTH (TOTAL_COUNT_WIDTH)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .q_status          (q_status),
        .q_item            (q_item),
        .pop               (pop),
        .clearing          (clearing),
        .done              (done),
        .granted           (granted),
        .key_open_count    (key_open_count),
        .key_pending_count (key_pending_count),
        .all_open_count    (all_open_count),
        .all_pending_count (all_pending_count),
        .error_code        (error_code)
    );

endmodule

FILE: dv/per_key_connection_admission_core_tb.sv
// Self-checking testbench for per_key_connection_admission_core: drives commands and
// APB writes, predicts every result in-line and checks each done strobe against it.
// Depends on pkca_pkg and the RTL under hdl/.
module per_key_connection_admission_core_tb
    import pkca_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [5:0]  key_index;
    logic [15:0] queued_requests;
    logic [15:0] client_connections;
    logic [15:0] client_limit;
    logic        throttle_denied;
    logic        done;
    logic        granted;
    logic [11:0] key_open_count;
    logic [11:0] key_pending_count;
    logic [15:0] all_open_count;
    logic [15:0] all_pending_count;
    logic [1:0]  error_code;

    per_key_connection_admission_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .start             (start),
        .busy              (busy),
        .opcode            (opcode),
        .key_index         (key_index),
        .queued_requests   (queued_requests),
        .client_connections(client_connections),
        .client_limit      (client_limit),
        .throttle_denied   (throttle_denied),
        .done              (done),
        .granted           (granted),
        .key_open_count    (key_open_count),
        .key_pending_count (key_pending_count),
        .all_open_count    (all_open_count),
        .all_pending_count (all_pending_count),
        .error_code        (error_code)
    );

    // 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Command / result records
    // ------------------------------------------------------------------
    typedef struct {
        op_t         op;
        logic [5:0]  key;
        logic [15:0] queued;
        logic [15:0] conns;
        logic [15:0] limit;
        logic        throttle;
    } conn_cmd_t;

    typedef struct {
        logic        granted;
        logic [11:0] key_open;
        logic [11:0] key_pend;
        logic [15:0] all_open;
        logic [15:0] all_pend;
        err_t        err;
    } admit_result_t;

    // Shadow copy of the admission state and the two limits
    logic [11:0] track_open [64];
    logic [11:0] track_pend [64];
    logic [15:0] track_open_sum;
    logic [15:0] track_pend_sum;
    logic [15:0] lim_total;
    logic [11:0] lim_key;

    admit_result_t admit_expected_q[$];
    int            mismatch_count;
    int            gap_max;        // sender idle cycles drawn from 0..gap_max

    // ------------------------------------------------------------------
    // Admission predictor: applies one command to the shadow state
    // ------------------------------------------------------------------
    function automatic admit_result_t admit_predict(conn_cmd_t c);
        admit_result_t r;
        logic [12:0]   key_sum;
        logic [16:0]   all_sum;
        r.granted = 1'b0;
        r.err     = ERR_NONE;
        // sums are one bit wider so a saturated counter cannot wrap the compare
        key_sum = {1'b0, track_open[c.key]} + {1'b0, track_pend[c.key]};
        all_sum = {1'b0, track_open_sum} + {1'b0, track_pend_sum};
        case (c.op)
            OP_TRY:
            begin
                if (c.conns < c.limit && all_sum < {1'b0, lim_total}
                    && key_sum < {1'b0, lim_key} && track_pend[c.key] < c.queued
                    && !c.throttle)
                begin
                    r.granted = 1'b1;
                    if (&track_pend[c.key]) r.err = ERR_SAT;
                    else track_pend[c.key] = track_pend[c.key] + 1'b1;
                    if (&track_pend_sum) r.err = ERR_SAT;
                    else track_pend_sum = track_pend_sum + 1'b1;
                end
            end
            OP_FINISH:
            begin
                if (track_pend[c.key] == '0) r.err = ERR_UNDER;
                else track_pend[c.key] = track_pend[c.key] - 1'b1;
                if (track_pend_sum == '0) r.err = ERR_UNDER;
                else track_pend_sum = track_pend_sum - 1'b1;
            end
            OP_ADD:
            begin
                if (&track_open[c.key]) r.err = ERR_SAT;
                else track_open[c.key] = track_open[c.key] + 1'b1;
                if (&track_open_sum) r.err = ERR_SAT;
                else track_open_sum = track_open_sum + 1'b1;
            end
            default:
            begin
                if (track_open[c.key] == '0) r.err = ERR_UNDER;
                else track_open[c.key] = track_open[c.key] - 1'b1;
                if (track_open_sum == '0) r.err = ERR_UNDER;
                else track_open_sum = track_open_sum - 1'b1;
            end
        endcase
        r.key_open = track_open[c.key];
        r.key_pend = track_pend[c.key];
        r.all_open = track_open_sum;
        r.all_pend = track_pend_sum;
        return r;
    endfunction

    function automatic conn_cmd_t cmd_of(op_t op, int key, int queued, int conns,
                                         int limit, bit throttle);
        conn_cmd_t c;
        c.op       = op;
        c.key      = key[5:0];
        c.queued   = queued[15:0];
        c.conns    = conns[15:0];
        c.limit    = limit[15:0];
        c.throttle = throttle;
        return c;
    endfunction

    // Mostly well-formed commands on keys below key_span so counts build up and the
    // limits actually bite; one in ten is fully random noise.
    function automatic conn_cmd_t random_cmd(int key_span);
        conn_cmd_t c;
        int        pick;
        int        lim;
        if ($urandom_range(0, 9) == 0)
        begin
            c.op       = op_t'($urandom_range(0, 3));
            c.key      = 6'($urandom);
            c.queued   = 16'($urandom);
            c.conns    = 16'($urandom);
            c.limit    = 16'($urandom);
            c.throttle = 1'($urandom);
            return c;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)      c.op = OP_TRY;
        else if (pick < 60) c.op = OP_FINISH;
        else if (pick < 85) c.op = OP_ADD;
        else                c.op = OP_REMOVE;
        c.key    = 6'($urandom_range(0, key_span - 1));
        c.queued = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        lim      = $urandom_range(1, 65535);
        c.limit  = 16'(lim);
        c.conns  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(lim, 65535))
                                               : 16'($urandom_range(0, lim - 1));
        c.throttle = ($urandom_range(0, 9) == 0);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting (line output capped, count is not)
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t ns  mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result checker: every done strobe is one transfer, no back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        admit_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (admit_expected_q.size() == 0)
                report_mismatch("result with nothing outstanding", 1, 0);
            else
            begin
                want = admit_expected_q.pop_front();
                if (granted !== want.granted)
                    report_mismatch("granted", granted, want.granted);
                if (key_open_count !== want.key_open)
                    report_mismatch("key_open_count", key_open_count, want.key_open);
                if (key_pending_count !== want.key_pend)
                    report_mismatch("key_pending_count", key_pending_count, want.key_pend);
                if (all_open_count !== want.all_open)
                    report_mismatch("all_open_count", all_open_count, want.all_open);
                if (all_pending_count !== want.all_pend)
                    report_mismatch("all_pending_count", all_pending_count, want.all_pend);
                if (error_code !== want.err)
                    report_mismatch("error_code", error_code, want.err);
            end
        end
    end

    // ------------------------------------------------------------------
    // Command sender: inputs change on the falling edge; the transfer is
    // taken at the rising edge where busy is low. start stays high after a
    // transfer so back-to-back commands need no extra edge.
    // ------------------------------------------------------------------
    task automatic send_cmd(conn_cmd_t c);
        int gap;
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode             <= c.op;
        key_index          <= c.key;
        queued_requests    <= c.queued;
        client_connections <= c.conns;
        client_limit       <= c.limit;
        throttle_denied    <= c.throttle;
        start              <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        admit_expected_q.push_back(admit_predict(c));
    endtask

    // Drop start, let every outstanding result arrive, then wait out a
    // margin before touching the registers.
    task automatic wait_quiet();
        @(negedge clk);
        start <= 1'b0;
        while (admit_expected_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB access: setup cycle, then access cycle; pready is tied high but
    // still waited on.
    // ------------------------------------------------------------------
    task automatic reg_write(logic sel, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read_check(logic sel, logic [31:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== want)
            report_mismatch(sel == REG_TOTAL_LIMIT ? "total_limit readback"
                                                   : "per_key_limit readback", prdata, want);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_limits(logic [15:0] total, logic [11:0] per_key);
        wait_quiet();
        reg_write(REG_TOTAL_LIMIT, {16'd0, total});
        reg_write(REG_PER_KEY_LIMIT, {20'd0, per_key});
        lim_total = total;
        lim_key   = per_key;
        reg_read_check(REG_TOTAL_LIMIT, {16'd0, total});
        reg_read_check(REG_PER_KEY_LIMIT, {20'd0, per_key});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Limits come up at their reset values.
    task automatic test_register_defaults();
        reg_read_check(REG_TOTAL_LIMIT, {16'd0, TOTAL_LIMIT_RESET});
        reg_read_check(REG_PER_KEY_LIMIT, {20'd0, PER_KEY_LIMIT_RESET});
    endtask

    // Decrements on a freshly cleared store: both counters blocked at zero.
    task automatic test_underflow_at_reset();
        send_cmd(cmd_of(OP_FINISH, 0, 0, 0, 0, 1'b0));
        send_cmd(cmd_of(OP_REMOVE, 0, 0, 0, 0, 1'b0));
        send_cmd(cmd_of(OP_REMOVE, 63, 65535, 65535, 65535, 1'b1));
    endtask

    // The client-limit and queued-demand try checks refusing on their own, the throttle,
    // a plain grant, and decrements where only the key counter sits at zero.
    task automatic test_try_rules();
        send_cmd(cmd_of(OP_ADD, 5, 0, 0, 0, 1'b0));
        send_cmd(cmd_of(OP_TRY, 5, 0, 0, 65535, 1'b0));         // no demand queued
        send_cmd(cmd_of(OP_TRY, 5, 65535, 0, 65535, 1'b0));     // grant
        send_cmd(cmd_of(OP_TRY, 5, 65535, 0, 65535, 1'b1));     // throttled
        send_cmd(cmd_of(OP_TRY, 5, 65535, 700, 700, 1'b0));     // client at limit
        send_cmd(cmd_of(OP_TRY, 5, 65535, 65535, 65535, 1'b0));
        send_cmd(cmd_of(OP_TRY, 5, 65535, 0, 0, 1'b0));
        send_cmd(cmd_of(OP_TRY, 5, 1, 0, 1, 1'b0));             // pending == queued
        send_cmd(cmd_of(OP_TRY, 63, 65535, 65534, 65535, 1'b0));
        send_cmd(cmd_of(OP_FINISH, 0, 0, 0, 0, 1'b0));          // key at zero, total not
        send_cmd(cmd_of(OP_REMOVE, 63, 0, 0, 0, 1'b0));         // key at zero, total not
        send_cmd(cmd_of(OP_FINISH, 5, 0, 0, 0, 1'b0));
        send_cmd(cmd_of(OP_REMOVE, 5, 0, 0, 0, 1'b0));
    endtask

    // Global and per-key limits refusing tries, including both at zero.
    task automatic test_admission_limits();
        set_limits(16'hFFFF, 12'd1);
        send_cmd(cmd_of(OP_ADD, 7, 0, 0, 0, 1'b0));
        send_cmd(cmd_of(OP_TRY, 7, 65535, 0, 65535, 1'b0));     // key full
        send_cmd(cmd_of(OP_TRY, 8, 65535, 0, 65535, 1'b0));     // grant
        set_limits(track_open_sum + track_pend_sum, 12'hFFF);
        send_cmd(cmd_of(OP_TRY, 9, 65535, 0, 65535, 1'b0));     // total full
        set_limits(16'd0, 12'd0);
        send_cmd(cmd_of(OP_TRY, 10, 65535, 0, 65535, 1'b0));
    endtask

    // Random traffic over a spread of limit settings; idle stretches and
    // no-idle stretches are mixed at random, with an occasional full drain.
    task automatic test_random_traffic();
        logic [15:0] phase_total [6];
        logic [11:0] phase_key   [6];
        int          span;
        phase_total = '{16'd1000, 16'd30, 16'd0, 16'hFFFF, 16'($urandom), 16'd1};
        phase_key   = '{12'd100, 12'd5, 12'd0, 12'hFFF, 12'($urandom), 12'd1};
        for (int p = 0; p < 6; p++)
        begin
            set_limits(phase_total[p], phase_key[p]);
            span = (p % 2 == 0) ? 4 : 64;
            for (int n = 0; n < 250; n++)
            begin
                if (n % 60 == 0)
                    gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
                if ($urandom_range(0, 49) == 0)
                    wait_quiet();
                send_cmd(random_cmd(span));
            end
        end
        gap_max = 10;
    endtask

    // Back-to-back burst of adds on two keys, then step back down and try.
    task automatic test_add_burst();
        set_limits(16'hFFFF, 12'hFFF);
        gap_max = 0;
        for (int k = 0; k < 2; k++)
            repeat (40) send_cmd(cmd_of(OP_ADD, k, 0, 0, 0, 1'b0));
        send_cmd(cmd_of(OP_ADD, 16, 0, 0, 0, 1'b0));
        send_cmd(cmd_of(OP_TRY, 0, 65535, 0, 65535, 1'b0));
        send_cmd(cmd_of(OP_REMOVE, 0, 0, 0, 0, 1'b0));
        send_cmd(cmd_of(OP_REMOVE, 16, 0, 0, 0, 1'b0));
        send_cmd(cmd_of(OP_TRY, 16, 65535, 0, 65535, 1'b0));
        gap_max = 10;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        start              = 1'b0;
        opcode             = OP_TRY;
        key_index          = '0;
        queued_requests    = '0;
        client_connections = '0;
        client_limit       = '0;
        throttle_denied    = 1'b0;
        mismatch_count     = 0;
        gap_max            = 10;
        for (int i = 0; i < 64; i++)
        begin
            track_open[i] = '0;
            track_pend[i] = '0;
        end
        track_open_sum = '0;
        track_pend_sum = '0;
        lim_total      = TOTAL_LIMIT_RESET;
        lim_key        = PER_KEY_LIMIT_RESET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // clearing pass after reset holds busy high
        do @(posedge clk); while (busy !== 1'b0);

        test_register_defaults();
        test_underflow_at_reset();
        test_try_rules();
        test_admission_limits();
        test_random_traffic();
        test_add_burst();

        wait_quiet();
        if (mismatch_count == 0)
            $display("per_key_connection_admission_core_tb: clean");
        else
            $display("per_key_connection_admission_core_tb: errors");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial
    begin
        #16000000;
        $display("per_key_connection_admission_core_tb: errors");
        $finish;
    end

endmodule

FILE: per_key_connection_admission_core.f
hdl/pkca_pkg.sv
hdl/pkca_front.sv
hdl/pkca_queue.sv
hdl/pkca_back.sv
hdl/per_key_connection_admission_core.sv
dv/per_key_connection_admission_core_tb.sv
